// ===== design/smavg_pkg.sv =====
// Shared types, constants and codes of the soil moisture averaging unit.
`default_nettype none

package smavg_pkg;

  localparam int RAW_W      = 12;
  localparam int MEAN_W     = 15;
  localparam int WINDOW     = 5;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int FULL_SCALE = 25600;  // 100 % in Q.8
  localparam int RAW_MAX    = 4095;   // rail code, marks a bad sample
  localparam int SUM_W      = $clog2(WINDOW * FULL_SCALE + 1);

  // Divider geometry: numerator covers raw span times full scale.
  localparam int NUM_W     = $clog2(RAW_MAX * FULL_SCALE + 1);
  localparam int DEN_W     = RAW_W;
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DQ_W      = DIV_STEPS * DIV_BITS;
  localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RAW_W;

  localparam logic [RAW_W-1:0] DRY_RESET = 12'd3000;
  localparam logic [RAW_W-1:0] WET_RESET = 12'd1200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRY  = 2'd0,
    CFG_WET  = 2'd1,
    CFG_B_EN = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CA,
    S_WCA,
    S_CB,
    S_WCB,
    S_WR,
    S_RD,
    S_SUM,
    S_MA,
    S_WMA,
    S_MB,
    S_WMB,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] probe_a_raw;
    logic [RAW_W-1:0] probe_b_raw;
  } in_data_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_a;
    logic              valid_a;
    logic [MEAN_W-1:0] mean_b;
    logic              valid_b;
  } out_data_t;

  typedef struct packed {
    logic             start;
    logic [DQ_W-1:0]  num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DQ_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/smavg_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module smavg_ram #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 15
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/smavg_div.sv =====
// Iterative restoring divider, several quotient bits per cycle.
`default_nettype none

module smavg_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smavg_pkg::div_req_t req,
  output smavg_pkg::div_rsp_t      rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [smavg_pkg::DSTEP_W-1:0]       step_r;
  logic [smavg_pkg::DQ_W-1:0]          q_r;
  logic [smavg_pkg::DQ_W-1:0]          q_nxt;
  logic [smavg_pkg::DEN_W-1:0]         rem_r;
  logic [smavg_pkg::DEN_W-1:0]         rem_nxt;
  logic [smavg_pkg::DEN_W-1:0]         den_r;

  // DIV_BITS shift/compare/subtract steps; remainder stays below den.
  always_comb begin
    logic [smavg_pkg::DEN_W:0] r_ext;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    r_ext   = '0;
    for (int k = 0; k < smavg_pkg::DIV_BITS; k++) begin
      r_ext = {rem_nxt, q_nxt[smavg_pkg::DQ_W-1]};
      q_nxt = {q_nxt[smavg_pkg::DQ_W-2:0], 1'b0};
      if (r_ext >= {1'b0, den_r}) begin
        rem_nxt  = smavg_pkg::DEN_W'(r_ext - {1'b0, den_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = r_ext[smavg_pkg::DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= smavg_pkg::DSTEP_W'(smavg_pkg::DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - smavg_pkg::DSTEP_W'(1);
        if (step_r == smavg_pkg::DSTEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.quo  = q_r;
  end

endmodule

`default_nettype wire

// ===== design/soil_moisture_average_unit.sv =====
// Top level: two-probe soil moisture calibration and moving average.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in      | in  | in_valid/in_ready  | in_data   : probe_a_raw, probe_b_raw
//  out     | out | out_valid/out_ready| out_data  : mean_a, valid_a, mean_b, valid_b
//  cfg     | in  | cfg_we             | cfg_index, cfg_data (dry, wet, B enable)
//
// Each beat makes four passes through the shared divider (two
// calibrations, two means; 3 quotient bits per cycle, 9 steps each)
// plus one ring read per averaged entry (1 to WINDOW).
// Reset is synchronous; rings read as zero through per-entry valid bits,
// so no clearing pass is needed after reset.
// The output register lets a new beat be accepted while a result waits;
// a finished result stalls in S_OUT only if the previous one is still held.
`default_nettype none

module soil_moisture_average_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire smavg_pkg::in_data_t                   in_data,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output smavg_pkg::out_data_t                       out_data,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [smavg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [smavg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [smavg_pkg::RAW_W-1:0] dry_r;
  logic [smavg_pkg::RAW_W-1:0] wet_r;
  logic                        b_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r  <= smavg_pkg::DRY_RESET;
      wet_r  <= smavg_pkg::WET_RESET;
      b_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        smavg_pkg::CFG_DRY:  dry_r  <= cfg_data;
        smavg_pkg::CFG_WET:  wet_r  <= cfg_data;
        smavg_pkg::CFG_B_EN: b_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Signals
  // ---------------------------------------------------------------------
  smavg_pkg::state_t             state_r;
  smavg_pkg::state_t             state_nxt;

  smavg_pkg::div_req_t           div_req;
  smavg_pkg::div_rsp_t           div_rsp;

  logic [smavg_pkg::RAW_W-1:0]   mag_a_r;
  logic [smavg_pkg::RAW_W-1:0]   mag_b_r;
  logic [smavg_pkg::RAW_W-1:0]   den_mag_r;
  logic                          ok_a_r;
  logic                          ok_b_r;
  logic [smavg_pkg::MEAN_W-1:0]  q_a_r;
  logic [smavg_pkg::MEAN_W-1:0]  q_b_r;
  logic [smavg_pkg::MEAN_W-1:0]  mean_a_r;
  logic [smavg_pkg::MEAN_W-1:0]  mean_b_r;
  logic [smavg_pkg::MEAN_W-1:0]  q_clamp;

  logic [smavg_pkg::SLOT_W-1:0]  slot_r;
  logic [smavg_pkg::SLOT_W-1:0]  slot_nxt;
  logic                          full_r;
  logic                          full_nxt;
  logic [smavg_pkg::CNT_W-1:0]   count_r;
  logic [smavg_pkg::CNT_W-1:0]   count_nxt;
  logic [smavg_pkg::SLOT_W-1:0]  rd_idx_r;
  logic                          rd_last;
  logic                          rd_pend_r;
  logic                          rd_vld_a_r;
  logic                          rd_vld_b_r;
  logic [smavg_pkg::WINDOW-1:0]  vld_a_r;
  logic [smavg_pkg::WINDOW-1:0]  vld_b_r;
  logic [smavg_pkg::SUM_W-1:0]   sum_a_r;
  logic [smavg_pkg::SUM_W-1:0]   sum_b_r;
  logic [smavg_pkg::MEAN_W-1:0]  rdata_a;
  logic [smavg_pkg::MEAN_W-1:0]  rdata_b;

  logic                          ram_we_a;
  logic                          ram_we_b;
  logic                          out_load;
  logic                          out_valid_r;
  smavg_pkg::out_data_t          out_data_r;

  // calibration prep, from the raw beat and the current registers
  logic                          den_neg;
  logic [smavg_pkg::RAW_W-1:0]   den_mag;
  logic                          cal_ok;
  logic [smavg_pkg::RAW_W-1:0]   prep_mag_a;
  logic [smavg_pkg::RAW_W-1:0]   prep_mag_b;
  logic                          prep_ok_a;
  logic                          prep_ok_b;

  // Magnitude of (dry - raw); zero when its sign disagrees with the span,
  // which makes the quotient zero (the low clamp) for free.
  function automatic logic [smavg_pkg::RAW_W-1:0] cal_mag(
    input logic [smavg_pkg::RAW_W-1:0] raw,
    input logic [smavg_pkg::RAW_W-1:0] dry,
    input logic                        dneg
  );
    logic                        nneg;
    logic [smavg_pkg::RAW_W-1:0] mag;
    nneg = raw > dry;
    mag  = nneg ? (raw - dry) : (dry - raw);
    if (mag != '0 && nneg != dneg) begin
      mag = '0;
    end
    return mag;
  endfunction

  function automatic logic raw_ok(input logic [smavg_pkg::RAW_W-1:0] raw);
    return (raw != '0) && (raw != smavg_pkg::RAW_W'(smavg_pkg::RAW_MAX));
  endfunction

  always_comb begin
    den_neg    = wet_r > dry_r;
    den_mag    = den_neg ? (wet_r - dry_r) : (dry_r - wet_r);
    cal_ok     = dry_r != wet_r;
    prep_mag_a = cal_mag(in_data.probe_a_raw, dry_r, den_neg);
    prep_mag_b = cal_mag(in_data.probe_b_raw, dry_r, den_neg);
    prep_ok_a  = cal_ok && raw_ok(in_data.probe_a_raw);
    prep_ok_b  = cal_ok && b_en_r && raw_ok(in_data.probe_b_raw);
  end

  // ring slot bookkeeping
  always_comb begin
    slot_nxt  = (slot_r == smavg_pkg::SLOT_W'(smavg_pkg::WINDOW - 1)) ?
                '0 : (slot_r + smavg_pkg::SLOT_W'(1));
    full_nxt  = full_r | (slot_nxt == '0);
    count_nxt = full_nxt ? smavg_pkg::CNT_W'(smavg_pkg::WINDOW) :
                           smavg_pkg::CNT_W'(slot_nxt);
    rd_last   = (smavg_pkg::CNT_W'(rd_idx_r) + smavg_pkg::CNT_W'(1)) == count_r;
  end

  // upper clamp of a calibration quotient to 100 %
  assign q_clamp = (div_rsp.quo > smavg_pkg::DQ_W'(smavg_pkg::FULL_SCALE)) ?
                   smavg_pkg::MEAN_W'(smavg_pkg::FULL_SCALE) :
                   div_rsp.quo[smavg_pkg::MEAN_W-1:0];

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smavg_pkg::S_IDLE: if (in_valid)     state_nxt = smavg_pkg::S_CA;
      smavg_pkg::S_CA:                     state_nxt = smavg_pkg::S_WCA;
      smavg_pkg::S_WCA:  if (div_rsp.done) state_nxt = smavg_pkg::S_CB;
      smavg_pkg::S_CB:                     state_nxt = smavg_pkg::S_WCB;
      smavg_pkg::S_WCB:  if (div_rsp.done) state_nxt = smavg_pkg::S_WR;
      smavg_pkg::S_WR:                     state_nxt = smavg_pkg::S_RD;
      smavg_pkg::S_RD:   if (rd_last)      state_nxt = smavg_pkg::S_SUM;
      smavg_pkg::S_SUM:                    state_nxt = smavg_pkg::S_MA;
      smavg_pkg::S_MA:                     state_nxt = smavg_pkg::S_WMA;
      smavg_pkg::S_WMA:  if (div_rsp.done) state_nxt = smavg_pkg::S_MB;
      smavg_pkg::S_MB:                     state_nxt = smavg_pkg::S_WMB;
      smavg_pkg::S_WMB:  if (div_rsp.done) state_nxt = smavg_pkg::S_OUT;
      smavg_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = smavg_pkg::S_IDLE;
      end
      default:                             state_nxt = smavg_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready      = 1'b0;
    ram_we_a      = 1'b0;
    ram_we_b      = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = den_mag_r;
    case (state_r)
      smavg_pkg::S_IDLE: in_ready = 1'b1;
      smavg_pkg::S_CA: begin
        div_req.start = 1'b1;
        div_req.num   = smavg_pkg::DQ_W'(mag_a_r) *
                        smavg_pkg::DQ_W'(smavg_pkg::FULL_SCALE);
      end
      smavg_pkg::S_CB: begin
        div_req.start = 1'b1;
        div_req.num   = smavg_pkg::DQ_W'(mag_b_r) *
                        smavg_pkg::DQ_W'(smavg_pkg::FULL_SCALE);
      end
      smavg_pkg::S_WR: begin
        ram_we_a = ok_a_r;
        ram_we_b = ok_b_r;
      end
      smavg_pkg::S_MA: begin
        div_req.start = 1'b1;
        div_req.num   = smavg_pkg::DQ_W'(sum_a_r);
        div_req.den   = smavg_pkg::DEN_W'(count_r);
      end
      smavg_pkg::S_MB: begin
        div_req.start = 1'b1;
        div_req.num   = smavg_pkg::DQ_W'(sum_b_r);
        div_req.den   = smavg_pkg::DEN_W'(count_r);
      end
      smavg_pkg::S_OUT: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smavg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      vld_a_r     <= '0;
      vld_b_r     <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= state_r == smavg_pkg::S_RD;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == smavg_pkg::S_WR) begin
        slot_r <= slot_nxt;
        full_r <= full_nxt;
        if (ok_a_r) vld_a_r[slot_r] <= 1'b1;
        if (ok_b_r) vld_b_r[slot_r] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_vld_a_r <= vld_a_r[rd_idx_r];
    rd_vld_b_r <= vld_b_r[rd_idx_r];

    if (state_r == smavg_pkg::S_IDLE && in_valid) begin
      mag_a_r   <= prep_mag_a;
      mag_b_r   <= prep_mag_b;
      ok_a_r    <= prep_ok_a;
      ok_b_r    <= prep_ok_b;
      den_mag_r <= den_mag;
    end

    if (state_r == smavg_pkg::S_WCA && div_rsp.done) q_a_r <= q_clamp;
    if (state_r == smavg_pkg::S_WCB && div_rsp.done) q_b_r <= q_clamp;

    if (state_r == smavg_pkg::S_WR) begin
      count_r  <= count_nxt;
      rd_idx_r <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
    end else begin
      if (state_r == smavg_pkg::S_RD && !rd_last) begin
        rd_idx_r <= rd_idx_r + smavg_pkg::SLOT_W'(1);
      end
      // entries never written count as zero
      if (rd_pend_r) begin
        sum_a_r <= sum_a_r + (rd_vld_a_r ? smavg_pkg::SUM_W'(rdata_a) : '0);
        sum_b_r <= sum_b_r + (rd_vld_b_r ? smavg_pkg::SUM_W'(rdata_b) : '0);
      end
    end

    if (state_r == smavg_pkg::S_WMA && div_rsp.done) begin
      mean_a_r <= div_rsp.quo[smavg_pkg::MEAN_W-1:0];
    end
    if (state_r == smavg_pkg::S_WMB && div_rsp.done) begin
      mean_b_r <= div_rsp.quo[smavg_pkg::MEAN_W-1:0];
    end

    if (out_load) begin
      out_data_r.mean_a  <= ok_a_r ? mean_a_r : '0;
      out_data_r.valid_a <= ok_a_r;
      out_data_r.mean_b  <= ok_b_r ? mean_b_r : '0;
      out_data_r.valid_b <= ok_b_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Ring memories and shared divider
  // ---------------------------------------------------------------------
  smavg_ram #(
    .DEPTH (smavg_pkg::WINDOW),
    .WIDTH (smavg_pkg::MEAN_W)
  ) u_ring_a (
    .clk   (clk),
    .we    (ram_we_a),
    .waddr (slot_r),
    .wdata (q_a_r),
    .raddr (rd_idx_r),
    .rdata (rdata_a)
  );

  smavg_ram #(
    .DEPTH (smavg_pkg::WINDOW),
    .WIDTH (smavg_pkg::MEAN_W)
  ) u_ring_b (
    .clk   (clk),
    .we    (ram_we_b),
    .waddr (slot_r),
    .wdata (q_b_r),
    .raddr (rd_idx_r),
    .rdata (rdata_b)
  );

  smavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == smavg_pkg::S_WCA || state_r == smavg_pkg::S_WCB ||
                      state_r == smavg_pkg::S_WMA || state_r == smavg_pkg::S_WMB))
    else $error("divider finished outside a wait state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smavg_pkg::S_RD) |->
      (count_r != '0 && count_r <= smavg_pkg::CNT_W'(smavg_pkg::WINDOW)))
    else $error("average count out of range");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("ring full flag dropped");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.valid_a) |-> (out_data_r.mean_a == '0))
    else $error("invalid probe A carries a nonzero mean");

  a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_data_r.mean_a <= smavg_pkg::MEAN_W'(smavg_pkg::FULL_SCALE) &&
       out_data_r.mean_b <= smavg_pkg::MEAN_W'(smavg_pkg::FULL_SCALE)))
    else $error("mean above full scale");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the soil moisture calibration and averaging unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_TOP = smavg_pkg::RAW_MAX;

  // ---------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  smavg_pkg::in_data_t  in_data = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  smavg_pkg::out_data_t out_data;

  logic                             cfg_we = 1'b0;
  logic [smavg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [smavg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  soil_moisture_average_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: calibration registers and both moisture rings
  // ---------------------------------------------------------------------
  logic [smavg_pkg::RAW_W-1:0]  cal_dry  = smavg_pkg::DRY_RESET;
  logic [smavg_pkg::RAW_W-1:0]  cal_wet  = smavg_pkg::WET_RESET;
  bit                           b_enable = 1'b1;
  logic [smavg_pkg::MEAN_W-1:0] ring_a [smavg_pkg::WINDOW];
  logic [smavg_pkg::MEAN_W-1:0] ring_b [smavg_pkg::WINDOW];
  int unsigned                  wr_slot = 0;
  bit                           wrapped = 1'b0;

  smavg_pkg::in_data_t  pending_samples[$];  // samples waiting for the driver
  smavg_pkg::out_data_t expected_means[$];   // predicted results, oldest first

  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned results_seen   = 0;
  int unsigned errors         = 0;
  int unsigned settings_used  = 0;
  int unsigned invalid_a_seen = 0;
  int unsigned invalid_b_seen = 0;

  // 0: back-to-back, 1: random gaps
  int tx_mode = 1;
  int rx_mode = 1;
  int rx_hold_req = 0;  // one-shot request for a long receiver hold-off

  initial begin
    for (int i = 0; i < smavg_pkg::WINDOW; i++) begin
      ring_a[i] = '0;
      ring_b[i] = '0;
    end
  end

  // Two-point calibration to Q.8 percent. Returns 0 for a rail sample or an
  // undefined calibration (dry equals wet).
  function automatic bit calibrate(input logic [smavg_pkg::RAW_W-1:0] raw,
                                   output logic [smavg_pkg::MEAN_W-1:0] q);
    int unsigned num_mag, den_mag, val;
    bit          num_neg, den_neg;
    q = '0;
    if (raw == '0 || raw == smavg_pkg::RAW_W'(RAW_TOP) || cal_dry == cal_wet)
      return 1'b0;
    num_neg = raw > cal_dry;
    num_mag = num_neg ? raw - cal_dry : cal_dry - raw;
    den_neg = cal_wet > cal_dry;
    den_mag = den_neg ? cal_wet - cal_dry : cal_dry - cal_wet;
    // opposite signs: the sample sits past the dry end, so 0 %
    if (num_mag != 0 && num_neg != den_neg) begin
      val = 0;
    end else begin
      val = (num_mag * smavg_pkg::FULL_SCALE) / den_mag;
      if (val > smavg_pkg::FULL_SCALE)
        val = smavg_pkg::FULL_SCALE;
    end
    q = smavg_pkg::MEAN_W'(val);
    return 1'b1;
  endfunction

  // Store the calibrated samples, advance the shared slot and queue the means.
  function automatic void predict_means(input smavg_pkg::in_data_t s);
    smavg_pkg::out_data_t         e;
    logic [smavg_pkg::MEAN_W-1:0] qa, qb;
    bit                           va, vb;
    int unsigned                  n, sa, sb;
    va = calibrate(s.probe_a_raw, qa);
    vb = 1'b0;
    qb = '0;
    if (b_enable)
      vb = calibrate(s.probe_b_raw, qb);
    if (va)
      ring_a[wr_slot] = qa;
    if (vb)
      ring_b[wr_slot] = qb;
    wr_slot = (wr_slot == smavg_pkg::WINDOW - 1) ? 0 : wr_slot + 1;
    if (wr_slot == 0)
      wrapped = 1'b1;
    n = wrapped ? smavg_pkg::WINDOW : ((wr_slot > 0) ? wr_slot : 1);
    sa = 0;
    sb = 0;
    for (int i = 0; i < n; i++) begin
      sa += ring_a[i];
      sb += ring_b[i];
    end
    e.mean_a  = va ? smavg_pkg::MEAN_W'(sa / n) : '0;
    e.valid_a = va;
    e.mean_b  = vb ? smavg_pkg::MEAN_W'(sb / n) : '0;
    e.valid_b = vb;
    expected_means.push_back(e);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one beat at a time from pending_samples
  // ---------------------------------------------------------------------
  int  send_gap = 0;
  bit  tx_busy;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_busy = in_valid;
      if (in_valid && in_ready) begin
        // prediction uses the registers in force at acceptance
        predict_means(in_data);
        accepted_total++;
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(tx_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result beat and throttles out_ready
  // ---------------------------------------------------------------------
  int                   stall_left = 0;
  int                   hold_left  = 0;
  smavg_pkg::out_data_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result beat: %p", $realtime, out_data);
        end else begin
          want = expected_means.pop_front();
          if (!out_data.valid_a) invalid_a_seen++;
          if (!out_data.valid_b) invalid_b_seen++;
          if (out_data.mean_a  !== want.mean_a  || out_data.valid_a !== want.valid_a ||
              out_data.mean_b  !== want.mean_b  || out_data.valid_b !== want.valid_b) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] result %0d: exp a=%0d/%0b b=%0d/%0b, got a=%0d/%0b b=%0d/%0b",
                       $realtime, results_seen, want.mean_a, want.valid_a, want.mean_b,
                       want.valid_b, out_data.mean_a, out_data.valid_a, out_data.mean_b,
                       out_data.valid_b);
          end
        end
        stall_left = pick_gap(rx_mode);
      end
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_sample(input int a, input int b);
    smavg_pkg::in_data_t s;
    s.probe_a_raw = smavg_pkg::RAW_W'(a);
    s.probe_b_raw = smavg_pkg::RAW_W'(b);
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // Block until every queued beat went in and every result came out.
  task automatic wait_drain();
    do @(posedge clk);
    while (accepted_total != queued_total || expected_means.size() != 0);
  endtask

  // Writes all three registers on back-to-back cycles; block must be idle.
  task automatic apply_settings(input int dry, input int wet, input bit en);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= smavg_pkg::CFG_DRY;
    cfg_data  <= smavg_pkg::CFG_DATA_W'(dry);
    @(posedge clk);
    cfg_index <= smavg_pkg::CFG_WET;
    cfg_data  <= smavg_pkg::CFG_DATA_W'(wet);
    @(posedge clk);
    cfg_index <= smavg_pkg::CFG_B_EN;
    cfg_data  <= smavg_pkg::CFG_DATA_W'(en);
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_dry  = smavg_pkg::RAW_W'(dry);
    cal_wet  = smavg_pkg::RAW_W'(wet);
    b_enable = en;
    settings_used++;
  endtask

  // Mostly inside the calibrated span, some rails, some anywhere.
  function automatic int pick_raw();
    int r, lo, hi;
    lo = (cal_dry < cal_wet) ? cal_dry : cal_wet;
    hi = (cal_dry < cal_wet) ? cal_wet : cal_dry;
    r = $urandom_range(0, 99);
    if (r < 8)
      return $urandom_range(0, 1) ? RAW_TOP : 0;
    if (r < 30)
      return $urandom_range(0, RAW_TOP);
    if (r < 36)
      return $urandom_range(0, 1) ? hi : lo;
    return $urandom_range(lo, hi);
  endfunction

  int dry_v, wet_v, x, y;
  bit en_v;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset calibration (dry 3000, wet 1200, probe B on).
    // The first four beats run before the ring wraps.
    push_sample(2100, 2100);   // mid span, single-entry mean
    push_sample(0, RAW_TOP);   // both rails: nothing stored, slot still moves
    push_sample(RAW_TOP, 0);
    push_sample(1, RAW_TOP - 1); // past wet clamps to 100 %, past dry to 0 %
    push_sample(3000, 1200);   // exact end points, ring wraps here
    push_sample(1200, 3000);
    push_sample(3500, 100);
    push_sample(1201, 2999);
    push_sample(2999, 1201);
    push_sample(0, 2000);      // stale entries from skipped slots stay put
    push_sample(2000, RAW_TOP);
    push_sample(RAW_TOP, RAW_TOP);
    wait_drain();

    apply_settings(2000, 2000, 1'b1);  // undefined calibration
    push_sample(2000, 2000);
    push_sample(1, RAW_TOP - 1);
    push_sample(1000, 3000);
    wait_drain();

    apply_settings(0, RAW_TOP, 1'b1);  // reversed, full scale
    push_sample(1, RAW_TOP - 1);
    push_sample(2048, 2048);
    push_sample(RAW_TOP - 1, 1);
    wait_drain();

    apply_settings(RAW_TOP, 0, 1'b1);  // normal, full scale
    push_sample(1, RAW_TOP - 1);
    push_sample(2048, 100);
    wait_drain();

    apply_settings(3000, 1200, 1'b0);  // probe B not fitted
    push_sample(2100, 2100);
    push_sample(1500, 0);
    wait_drain();

    // Random phases, a fresh calibration each time.
    for (int ph = 0; ph < 10; ph++) begin
      wait_drain();
      x = $urandom_range(0, RAW_TOP);
      y = $urandom_range(0, RAW_TOP);
      case ($urandom_range(0, 9))
        0, 1:    begin dry_v = (x < y) ? x : y; wet_v = (x < y) ? y : x; end
        2:       begin dry_v = x; wet_v = x; end
        default: begin dry_v = (x < y) ? y : x; wet_v = (x < y) ? x : y; end
      endcase
      if (ph == 1) begin dry_v = RAW_TOP; wet_v = 0; end
      if (ph == 4) begin dry_v = 0; wet_v = RAW_TOP; end
      if (ph == 7) wet_v = dry_v;
      en_v = (ph == 8) ? 1'b0 : ($urandom_range(0, 4) != 0);
      apply_settings(dry_v, wet_v, en_v);

      tx_mode = (ph == 3) ? 0 : 1;
      rx_mode = (ph == 3 || ph == 6) ? 0 : 1;
      if (ph == 2) begin
        // sender keeps offering while the receiver sits out a long stretch
        tx_mode = 0;
        for (int i = 0; i < 183; i++)
          push_sample(pick_raw(), pick_raw());
        rx_hold_req = 400;
      end else if (ph == 5) begin
        // sender stops until the pipeline is empty, in short bursts
        for (int i = 0; i < 183; i++) begin
          push_sample(pick_raw(), pick_raw());
          if (i % 15 == 14)
            wait_drain();
        end
      end else begin
        for (int i = 0; i < 183; i++)
          push_sample(pick_raw(), pick_raw());
      end
    end

    wait_drain();
    repeat (60) @(posedge clk);
    if (expected_means.size() != 0)
      errors++;

    $display("Checked %0d result beats from %0d samples over %0d calibration settings;",
             results_seen, accepted_total, settings_used);
    $display("probe A invalid in %0d beats, probe B invalid or off in %0d.",
             invalid_a_seen, invalid_b_seen);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
